FILE: hw/rtl/assert_macros.svh
// Assertion macros for the port checker.
// Each macro wraps one concurrent assertion that reports through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define LSD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Clocked assertion that is checked in every cycle, reset included.
`define LSD_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

FILE: hw/rtl/lsd_pkg.sv
// -----------------------------------------------------------------------------
// lsd_pkg
// Widths, register indexes and reset values for the Laplacian sharpener.
// -----------------------------------------------------------------------------
`default_nettype none

package lsd_pkg;

   // Pixel and noise widths.
   localparam int PIXEL_BITS = 14;
   localparam int NOISE_BITS = 16;

   // Control register port.
   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = 16;

   // Register widths.
   localparam int STRENGTH_BITS = 16;
   localparam int DSTR_BITS     = 8;

   // Register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STRENGTH        = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_VALUE       = 8'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DITHER_ENABLE   = 8'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DITHER_STRENGTH = 8'd3;

   // Fixed-point shift: gain and noise products are in units of 1/65536.
   localparam int FRAC_SHIFT = 16;

   // Reset value of the upper clamp bound.
   localparam logic [PIXEL_BITS-1:0] MAX_VALUE_RESET = PIXEL_BITS'(255);

   typedef logic [PIXEL_BITS-1:0] pixel_type;

endpackage

`default_nettype wire

FILE: hw/rtl/laplacian_sharpen_dither_top.sv
// An accepted request beat is registered in every stage in turn before it leaves as its response beat.
// Throughput: one pixel per cycle while rsp_ready is high; the four stages stall together only where
// a full stage meets a full stage ahead of it, so bubbles are squeezed out.
// The 18x16 gain multiply shares its stage only with the dither offset; the output stage is a register.
// Reset is synchronous: it empties the pipeline and restores register defaults.
// -----------------------------------------------------------------------------
// laplacian_sharpen_dither_top
// Five-point Laplacian sharpener with gain, clamp and optional dither noise.
// -----------------------------------------------------------------------------
`default_nettype none

module laplacian_sharpen_dither_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Request channel.
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [lsd_pkg::PIXEL_BITS-1:0]      req_center_pixel,
   input  wire logic [lsd_pkg::PIXEL_BITS-1:0]      req_left_pixel,
   input  wire logic [lsd_pkg::PIXEL_BITS-1:0]      req_right_pixel,
   input  wire logic [lsd_pkg::PIXEL_BITS-1:0]      req_top_pixel,
   input  wire logic [lsd_pkg::PIXEL_BITS-1:0]      req_bottom_pixel,
   input  wire logic [lsd_pkg::NOISE_BITS-1:0]      req_noise_word,
   // Response channel.
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [lsd_pkg::PIXEL_BITS-1:0]           rsp_sharpened_pixel,
   // Control register write channel.
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [lsd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [lsd_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int PB   = lsd_pkg::PIXEL_BITS;
   localparam int NB   = lsd_pkg::NOISE_BITS;
   localparam int SB   = lsd_pkg::STRENGTH_BITS;
   localparam int DB   = lsd_pkg::DSTR_BITS;
   localparam int FS   = lsd_pkg::FRAC_SHIFT;
   // Weight: 4*c minus four pixels, plus sign.
   localparam int WB   = PB + 4;
   // Sum of four neighbours.
   localparam int SUMB = PB + 2;
   // Weight times gain.
   localparam int PRB  = WB + SB;
   // Dither multiplier 2*ds+1 and noise product.
   localparam int MB   = DB + 1;
   localparam int NPB  = NB + MB;
   // Dither offset, signed.
   localparam int DOB  = MB + 1;
   // Sharpened sum before the first clamp.
   localparam int VB   = PRB - FS + 3;
   // Dithered sum before the second clamp.
   localparam int V2B  = PB + 2;

   // Control registers.
   logic signed [SB-1:0] strength_ff;
   logic [PB-1:0]        max_value_ff;
   logic                 dither_enable_ff;
   logic [DB-1:0]        dither_strength_ff;

   // Register writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         strength_ff        <= '0;
         max_value_ff       <= lsd_pkg::MAX_VALUE_RESET;
         dither_enable_ff   <= 1'b0;
         dither_strength_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            lsd_pkg::CSR_STRENGTH:        strength_ff        <= $signed(csr_wdata[SB-1:0]);
            lsd_pkg::CSR_MAX_VALUE:       max_value_ff       <= csr_wdata[PB-1:0];
            lsd_pkg::CSR_DITHER_ENABLE:   dither_enable_ff   <= csr_wdata[0];
            lsd_pkg::CSR_DITHER_STRENGTH: dither_strength_ff <= csr_wdata[DB-1:0];
            default: begin
            end
         endcase
      end
   end

   // Stage valid bits and the backpressure chain: a stage loads when it is
   // empty or the stage ahead of it moves on in the same cycle.
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_ready, s2_ready, s3_ready, s4_ready;

   assign s4_ready  = !s4_valid_ff || rsp_ready;
   assign s3_ready  = !s3_valid_ff || s4_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_ready) begin
            s4_valid_ff <= s3_valid_ff;
         end
      end
   end

   // Stage 1: Laplacian weight and the noise product.
   logic [SUMB-1:0]      s1_sum;
   logic signed [WB-1:0] s1_w_in, s1_w_ff;
   logic [NPB-1:0]       s1_nprod_in, s1_nprod_ff;
   logic [MB-1:0]        s1_mul;
   logic [PB-1:0]        s1_center_ff;

   always_comb begin
      s1_sum = SUMB'(req_left_pixel) + SUMB'(req_right_pixel)
             + SUMB'(req_top_pixel) + SUMB'(req_bottom_pixel);
      s1_w_in = $signed({2'b00, req_center_pixel, 2'b00}) - $signed(WB'(s1_sum));
      s1_mul = {dither_strength_ff, 1'b1};
      s1_nprod_in = NPB'(req_noise_word) * NPB'(s1_mul);
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_w_ff      <= s1_w_in;
         s1_nprod_ff  <= s1_nprod_in;
         s1_center_ff <= req_center_pixel;
      end
   end

   // Stage 2: weight times gain, and the signed dither offset.
   logic signed [PRB-1:0] s2_prod_in, s2_prod_ff;
   logic signed [DOB-1:0] s2_doff_in, s2_doff_ff;
   logic signed [WB-1:0]  s2_w_ff;
   logic [PB-1:0]         s2_center_ff;

   always_comb begin
      s2_prod_in = PRB'(s1_w_ff) * PRB'(strength_ff);
      s2_doff_in = $signed({2'b00, dither_strength_ff})
                 - $signed({1'b0, s1_nprod_ff[NPB-1:FS]});
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_prod_ff   <= s2_prod_in;
         s2_doff_ff   <= s2_doff_in;
         s2_w_ff      <= s1_w_ff;
         s2_center_ff <= s1_center_ff;
      end
   end

   // Stage 3: round, add to the centre pixel (plus the weight for a negative gain), clamp.
   logic signed [PRB:0]   s3_round;
   logic signed [VB-1:0]  s3_sum;
   logic [PB-1:0]         s3_pix_in, s3_pix_ff;
   logic signed [DOB-1:0] s3_doff_ff;

   always_comb begin
      s3_round = (PRB+1)'(s2_prod_ff) + (PRB+1)'(1 << (FS - 1));
      // The shifted coefficient keeps its sign when it is widened.
      s3_sum = VB'($signed(s3_round[PRB:FS])) + $signed(VB'({1'b0, s2_center_ff}));
      if (strength_ff < 0) begin
         s3_sum = s3_sum + VB'(s2_w_ff);
      end
      if (s3_sum < 0) begin
         s3_pix_in = '0;
      end else if (s3_sum > $signed(VB'({1'b0, max_value_ff}))) begin
         s3_pix_in = max_value_ff;
      end else begin
         s3_pix_in = s3_sum[PB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         s3_pix_ff  <= s3_pix_in;
         s3_doff_ff <= s2_doff_ff;
      end
   end

   // Stage 4: optional dither and the second clamp, into the output register.
   logic signed [V2B-1:0] s4_sum;
   logic [PB-1:0]         s4_pix_in, s4_pix_ff;

   always_comb begin
      s4_sum = $signed(V2B'({1'b0, s3_pix_ff})) + V2B'(s3_doff_ff);
      if (!dither_enable_ff) begin
         s4_pix_in = s3_pix_ff;
      end else if (s4_sum < 0) begin
         s4_pix_in = '0;
      end else if (s4_sum > $signed(V2B'({1'b0, max_value_ff}))) begin
         s4_pix_in = max_value_ff;
      end else begin
         s4_pix_in = s4_sum[PB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (s4_ready) begin
         s4_pix_ff <= s4_pix_in;
      end
   end

   assign rsp_valid           = s4_valid_ff;
   assign rsp_sharpened_pixel = s4_pix_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/lsd_checker.sv
// -----------------------------------------------------------------------------
// lsd_port_checker
// Port-level checks on the sharpener's handshakes, bound to the top level.
// -----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lsd_port_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_ready,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic [lsd_pkg::PIXEL_BITS-1:0] rsp_sharpened_pixel
);

   // A stalled response beat stays put until it is taken.
   `LSD_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sharpened_pixel))

   // Reset leaves the pipeline empty and ready for a request beat.
   `LSD_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_valid && req_ready)

   // With the output side moving, the whole pipeline moves.
   `LSD_ASSERT(a_flow_through, clock, reset, rsp_ready |-> req_ready)

   // An empty output register never holds back the input side.
   `LSD_ASSERT(a_empty_out_ready, clock, reset, !rsp_valid |-> req_ready)

   // A request beat that is held off stays offered until it is taken.
   `LSD_ASSERT(a_req_hold, clock, reset, req_valid && !req_ready |=> req_valid)

endmodule

bind laplacian_sharpen_dither_top lsd_port_checker u_lsd_port_checker (.*);

`default_nettype wire

FILE: test/lsd_checker.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Laplacian sharpener scoreboard
// Watches the request, response and register channels of the sharpener. For
// every request beat it predicts the sharpened pixel from its own copy of the
// registers and queues it. Each response beat is compared with the oldest
// prediction. It reports the number of predictions still waiting and the
// number of failures to the testbench top.
// -----------------------------------------------------------------------------

module lsd_checker
   import lsd_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic                        req_ready,
   input  wire logic [PIXEL_BITS-1:0]       req_center_pixel,
   input  wire logic [PIXEL_BITS-1:0]       req_left_pixel,
   input  wire logic [PIXEL_BITS-1:0]       req_right_pixel,
   input  wire logic [PIXEL_BITS-1:0]       req_top_pixel,
   input  wire logic [PIXEL_BITS-1:0]       req_bottom_pixel,
   input  wire logic [NOISE_BITS-1:0]       req_noise_word,
   input  wire logic                        rsp_valid,
   input  wire logic                        rsp_ready,
   input  wire logic [PIXEL_BITS-1:0]       rsp_sharpened_pixel,
   input  wire logic                        csr_valid,
   input  wire logic                        csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]    csr_wdata,
   output int unsigned                      outstanding,
   output int unsigned                      error_count
);

   // Rounding bias: half of one whole unit, in units of 1/65536.
   localparam longint ROUND_HALF = longint'(1) << (FRAC_SHIFT - 1);

   // Shadow copy of the control registers.
   logic signed [STRENGTH_BITS-1:0] gain;
   pixel_type                       clamp_top;
   logic                            dither_on;
   logic [DSTR_BITS-1:0]            dither_amp;

   // Sharpened pixels predicted but not yet seen on the response channel.
   pixel_type sharpened_due[$];
   pixel_type due;

   // Limits a level to the range 0..clamp_top.
   function automatic longint clamp_level(input longint level);
      if (level < 0)
         return 0;
      if (level > longint'(clamp_top))
         return longint'(clamp_top);
      return level;
   endfunction

   // Weight, rounded gain term, optional add-weight, clamp, then dither.
   function automatic pixel_type sharpen_pixel(input pixel_type c, input pixel_type l,
                                               input pixel_type r, input pixel_type t,
                                               input pixel_type b,
                                               input logic [NOISE_BITS-1:0] noise);
      longint weight;
      longint coef;
      longint level;
      longint spread;
      weight = 4 * longint'(c)
               - (longint'(l) + longint'(r) + longint'(t) + longint'(b));
      coef   = (weight * longint'(gain) + ROUND_HALF) >>> FRAC_SHIFT;
      level  = longint'(c) + coef;
      if (gain < 0)
         level = level + weight;
      level = clamp_level(level);
      if (dither_on) begin
         spread = longint'(dither_amp)
                  - ((longint'(noise) * (2 * longint'(dither_amp) + 1)) >>> FRAC_SHIFT);
         level  = clamp_level(level + spread);
      end
      return pixel_type'(level);
   endfunction

   // Compare response beats, queue predictions and track register writes.
   always @(posedge clock) begin
      if (reset) begin
         sharpened_due.delete();
         gain        <= '0;
         clamp_top   <= MAX_VALUE_RESET;
         dither_on   <= 1'b0;
         dither_amp  <= '0;
         outstanding <= 0;
         error_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (sharpened_due.size() == 0) begin
               $error("sharpened_pixel: expected no beat, actual %0d", rsp_sharpened_pixel);
               error_count <= error_count + 1;
            end else begin
               due = sharpened_due.pop_front();
               if (rsp_sharpened_pixel !== due) begin
                  $error("sharpened_pixel: expected %0d, actual %0d", due,
                         rsp_sharpened_pixel);
                  error_count <= error_count + 1;
               end
            end
         end

         if (req_valid && req_ready)
            sharpened_due.push_back(sharpen_pixel(req_center_pixel, req_left_pixel,
                                                  req_right_pixel, req_top_pixel,
                                                  req_bottom_pixel, req_noise_word));

         // Writes to an unknown index leave every register as it was.
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_STRENGTH:        gain       <= csr_wdata;
               CSR_MAX_VALUE:       clamp_top  <= csr_wdata[PIXEL_BITS-1:0];
               CSR_DITHER_ENABLE:   dither_on  <= csr_wdata[0];
               CSR_DITHER_STRENGTH: dither_amp <= csr_wdata[DSTR_BITS-1:0];
               default: ;
            endcase
         end

         outstanding <= sharpened_due.size();
      end
   end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Laplacian sharpener testbench
// Drives the sharpener through a short directed pass over the pixel and noise
// extremes under three register settings, then through a dozen random phases
// with fresh settings each. Requests come in bursts with random gaps, and the
// response side stalls on its own pattern, including one long hold-off that
// backs the pipeline up. The scoreboard does the checking; this module gives
// the verdict.
// -----------------------------------------------------------------------------

module tb_top;
   import lsd_pkg::*;

   localparam int        STALL_LIMIT   = 4000;
   localparam int        LONG_HOLD     = 240;
   localparam int        SETTLE_CYCLES = 8;
   localparam int        RANDOM_PHASES = 12;
   localparam pixel_type PIXEL_TOP     = '1;
   // Index that no register answers to.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE = 8'hFF;

   logic                      clock            = 1'b0;
   logic                      reset            = 1'b1;
   logic                      req_valid        = 1'b0;
   logic                      req_ready;
   pixel_type                 req_center_pixel = '0;
   pixel_type                 req_left_pixel   = '0;
   pixel_type                 req_right_pixel  = '0;
   pixel_type                 req_top_pixel    = '0;
   pixel_type                 req_bottom_pixel = '0;
   logic [NOISE_BITS-1:0]     req_noise_word   = '0;
   logic                      rsp_valid;
   logic                      rsp_ready        = 1'b0;
   pixel_type                 rsp_sharpened_pixel;
   logic                      csr_valid        = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index        = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata        = '0;
   int unsigned               outstanding;
   int unsigned               error_count;
   logic                      streaming        = 1'b0;
   int unsigned               idle_cycles      = 0;

   laplacian_sharpen_dither_top u_top (.*);

   lsd_checker u_checker (.*);

   always #6 clock = ~clock;

   // Offers one pixel neighbourhood and holds it until the beat is taken.
   task automatic offer_pixel(input pixel_type c, input pixel_type l, input pixel_type r,
                              input pixel_type t, input pixel_type b,
                              input logic [NOISE_BITS-1:0] noise);
      req_valid        <= 1'b1;
      req_center_pixel <= c;
      req_left_pixel   <= l;
      req_right_pixel  <= r;
      req_top_pixel    <= t;
      req_bottom_pixel <= b;
      req_noise_word   <= noise;
      do @(posedge clock); while (!req_ready);
   endtask

   // One register write beat; the caller lowers csr_valid after the last one.
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Writes all four registers, with junk in the unused upper bits of the last three, and maybe the spare index.
   task automatic apply_settings(input logic [15:0] gain_word, input pixel_type bound,
                                 input bit dith, input logic [7:0] amp,
                                 input bit poke_spare);
      write_reg(CSR_STRENGTH, gain_word);
      write_reg(CSR_MAX_VALUE, {2'($urandom), bound});
      write_reg(CSR_DITHER_ENABLE, {15'($urandom), dith});
      write_reg(CSR_DITHER_STRENGTH, {8'($urandom), amp});
      if (poke_spare)
         write_reg(CSR_SPARE, 16'($urandom));
      csr_valid <= 1'b0;
   endtask

   // Waits until every predicted pixel has come back.
   task automatic wait_drained();
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Flat, ramp and corner neighbourhoods at the ends of the pixel range.
   task automatic offer_corners(input logic [NOISE_BITS-1:0] noise);
      offer_pixel('0, '0, '0, '0, '0, noise);
      offer_pixel(PIXEL_TOP, PIXEL_TOP, PIXEL_TOP, PIXEL_TOP, PIXEL_TOP, ~noise);
      offer_pixel(PIXEL_TOP, '0, '0, '0, '0, noise);
      offer_pixel('0, PIXEL_TOP, PIXEL_TOP, PIXEL_TOP, PIXEL_TOP, ~noise);
      offer_pixel(14'd8191, 14'd0, PIXEL_TOP, 14'd1, 14'd16382, 16'h8000);
      offer_pixel(14'd300, 14'd300, 14'd300, 14'd300, 14'd300, noise);
   endtask

   // A neighbour close to the centre value, kept inside the pixel range.
   function automatic pixel_type jitter_pixel(input pixel_type base, input int spread);
      int level;
      level = int'(base) + int'($urandom_range(0, 2 * spread)) - spread;
      if (level < 0)
         level = 0;
      if (level > int'(PIXEL_TOP))
         level = int'(PIXEL_TOP);
      return pixel_type'(level);
   endfunction

   // Stimulus: directed corners first, then random phases.
   initial begin : stimulus
      int unsigned           phase;
      int unsigned           quota;
      int unsigned           sent;
      int unsigned           burst;
      int unsigned           gap;
      int unsigned           k;
      int                    spread;
      bit                    steady;
      logic [15:0]           gain_word;
      pixel_type             bound;
      pixel_type             ceiling;
      bit                    dith;
      logic [7:0]            amp;
      pixel_type             c, l, r, t, b;
      logic [NOISE_BITS-1:0] n;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Register defaults after reset: dither off, so the noise is ignored.
      offer_corners(16'h0000);
      req_valid <= 1'b0;
      wait_drained();

      // Most negative gain in add-weight mode, full range, strongest dither.
      apply_settings(16'h8000, PIXEL_TOP, 1'b1, 8'hFF, 1'b0);
      offer_corners(16'hFFFF);
      req_valid <= 1'b0;
      wait_drained();

      // Largest positive gain with a clamp bound of zero; also a stray write.
      apply_settings(16'h7FFF, 14'd0, 1'b1, 8'h00, 1'b1);
      offer_corners(16'h0000);
      req_valid <= 1'b0;
      wait_drained();

      streaming <= 1'b1;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin gain_word = 16'h7FFF; bound = PIXEL_TOP; dith = 1'b1; amp = 8'hFF; end
            1: begin gain_word = 16'h8000; bound = 14'd255;   dith = 1'b0; amp = 8'h00; end
            2: begin gain_word = 16'h0000; bound = 14'd0;     dith = 1'b1; amp = 8'd17; end
            3: begin gain_word = 16'hFFFF; bound = 14'd1023;  dith = 1'b1; amp = 8'h00; end
            default: begin
               case ($urandom_range(0, 3))
                  0:       gain_word = 16'(int'($urandom_range(0, 4096)) - 2048);
                  1:       gain_word = 16'($urandom);
                  2:       gain_word = 16'(int'($urandom_range(0, 64)) - 32);
                  default: gain_word = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
               endcase
               case ($urandom_range(0, 3))
                  0:       bound = 14'd255;
                  1:       bound = PIXEL_TOP;
                  2:       bound = pixel_type'($urandom_range(0, 300));
                  default: bound = pixel_type'($urandom);
               endcase
               dith = 1'($urandom_range(0, 1));
               amp  = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
            end
         endcase
         apply_settings(gain_word, bound, dith, amp, $urandom_range(0, 3) == 0);

         ceiling = (bound < 14'd16) ? 14'd16 : bound;
         quota   = $urandom_range(100, 200);
         steady  = ($urandom_range(0, 3) == 0);
         sent    = 0;
         while (sent < quota) begin
            burst = $urandom_range(1, 40);
            for (k = 0; k < burst && sent < quota; k++) begin
               // Mostly smooth neighbourhoods, so the result is not always clamped.
               case ($urandom_range(0, 7))
                  0, 1, 2, 3, 4: begin
                     c      = pixel_type'($urandom_range(0, ceiling));
                     spread = $urandom_range(0, 1) ? $urandom_range(0, 8)
                                                   : $urandom_range(0, 512);
                     l = jitter_pixel(c, spread);
                     r = jitter_pixel(c, spread);
                     t = jitter_pixel(c, spread);
                     b = jitter_pixel(c, spread);
                  end
                  5, 6: begin
                     c = pixel_type'($urandom_range(0, ceiling));
                     l = pixel_type'($urandom_range(0, ceiling));
                     r = pixel_type'($urandom_range(0, ceiling));
                     t = pixel_type'($urandom_range(0, ceiling));
                     b = pixel_type'($urandom_range(0, ceiling));
                  end
                  default: begin
                     c = pixel_type'($urandom);
                     l = pixel_type'($urandom);
                     r = pixel_type'($urandom);
                     t = pixel_type'($urandom);
                     b = pixel_type'($urandom);
                  end
               endcase
               if ($urandom_range(0, 7) == 0)
                  n = $urandom_range(0, 1) ? '1 : '0;
               else
                  n = NOISE_BITS'($urandom);
               offer_pixel(c, l, r, t, b, n);
               sent++;
            end

            // Gap between bursts; now and then wait for the pipeline to empty.
            if (!steady) begin
               gap = $urandom_range(0, 12);
               if ($urandom_range(0, 29) == 0) begin
                  req_valid <= 1'b0;
                  wait_drained();
               end else if (gap != 0) begin
                  req_valid <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
            end
         end
         req_valid <= 1'b0;
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Response side: stall patterns of random length, one long hold-off once
   // the random stream starts, and occasional shorter ones.
   initial begin : receiver
      int unsigned pattern;
      int unsigned span;
      int unsigned k;
      bit          held_long;

      held_long = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (streaming && !held_long) begin
            held_long = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if ($urandom_range(0, 24) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(30, 90)) @(posedge clock);
         end else begin
            pattern = $urandom_range(0, 3);
            span    = $urandom_range(8, 64);
            for (k = 0; k < span; k++) begin
               case (pattern)
                  0:       rsp_ready <= 1'b1;
                  1:       rsp_ready <= 1'($urandom_range(0, 1));
                  2:       rsp_ready <= ($urandom_range(0, 3) == 0);
                  default: rsp_ready <= k[0];
               endcase
               @(posedge clock);
            end
         end
      end
   end

   // Watchdog: too long without any beat on any channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
